// ===== src/text_console_writer_top_assert.svh =====
// ---------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent check forms, clocked on clk, off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// condition that holds at every clock edge
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent in one cycle forces the consequent in the next
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// shared command codes, character constants and the queued item type
// ---------------------------------------------------------------------------
package tcw_pkg;

	// command codes; codes 6 and 7 mean nothing
	typedef enum logic [2:0] {
		CMD_PUT_CURSOR = 3'd0,
		CMD_PUT_POS    = 3'd1,
		CMD_SET_CURSOR = 3'd2,
		CMD_SET_COLOR  = 3'd3,
		CMD_CLEAR      = 3'd4,
		CMD_READ       = 3'd5
	} cmd_t;

	// back end states
	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_READ,
		B_SCROLL,
		B_CLEAR
	} bstate_t;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

	// widest linear cell address over all legal screen sizes (32 x 128)
	localparam int CELL_ADDR_W = 12;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// classified item as it travels from front to back
	typedef struct packed {
		logic [2:0]             cmd;
		logic [7:0]             char_code;
		logic [4:0]             row;
		logic [6:0]             col;
		logic [7:0]             color;
		logic                   newline;
		logic                   on_screen;
		logic [CELL_ADDR_W-1:0] addr;
	} item_t;

endpackage

// ===== src/tcw_front.sv =====
// ---------------------------------------------------------------------------
// tcw_front
// accepts command items and classifies them: newline, screen bounds and
// linear cell address
// ---------------------------------------------------------------------------
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                start,
	input  logic                busy,
	input  logic [2:0]          command,
	input  logic [7:0]          char_code,
	input  logic [4:0]          row,
	input  logic [6:0]          col,
	input  logic [7:0]          color,
	output logic                push,
	output tcw_pkg::item_t      item
);
	import tcw_pkg::*;

	// handshake
	assign push = start && !busy;

	// classification
	always_comb begin
		item.cmd       = command;
		item.char_code = char_code;
		item.row       = row;
		item.col       = col;
		item.color     = color;
		item.newline   = (char_code == NEWLINE_CHAR);
		item.on_screen = ({1'b0, row} < 6'(ROWS)) && ({1'b0, col} < 8'(COLUMNS));
		item.addr      = CELL_ADDR_W'(row) * CELL_ADDR_W'(COLUMNS) + CELL_ADDR_W'(col);
	end

endmodule

// ===== src/tcw_queue.sv =====
// ---------------------------------------------------------------------------
// tcw_queue
// short item queue that decouples the front from the back
// ---------------------------------------------------------------------------
module tcw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcw_pkg::item_t push_item,
	input  logic           pop,
	output logic           valid,
	output logic           full,
	output tcw_pkg::item_t head
);
	import tcw_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// status
	assign valid = (count_q != '0);
	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`include "text_console_writer_top_assert.svh"

	`TCW_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "queue count past depth")
	`TCW_ASSERT_ALWAYS(a_no_pop_empty, !pop || (count_q != '0), "pop from empty queue")
	`TCW_ASSERT_ALWAYS(a_no_push_full, !push || (count_q != CW'(QUEUE_DEPTH)), "push to full queue")

endmodule

// ===== src/tcw_back.sv =====
// ---------------------------------------------------------------------------
// tcw_back
// carries out queued commands on the screen store: cursor, colour, cell
// writes and reads, scroll and clear sweeps, and the clearing pass after
// reset
// ---------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  tcw_pkg::item_t q_head,
	output logic           pop,
	output logic           init_busy,
	output logic           done,
	output logic [4:0]     cursor_row,
	output logic [6:0]     cursor_col,
	output logic [7:0]     current_color,
	output logic [15:0]    cell_data,
	output logic           ignored
);
	import tcw_pkg::*;

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int AW       = $clog2(CELLS);
	localparam int COPY_END = CELLS - COLUMNS;

	bstate_t        state_q, state_d;
	logic [AW-1:0]  ptr_q;
	logic           pend_s1;
	logic [AW-1:0]  pend_addr_s1;
	logic [15:0]    rdata_q;
	logic [15:0]    mem [CELLS];
	logic [4:0]     cur_r_q;
	logic [6:0]     cur_c_q;
	logic [7:0]     attr_q;
	logic [15:0]    fill_q;
	logic           done_q;
	logic [15:0]    cell_q;
	logic           ign_q;

	// control from the output block
	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	logic [15:0]    wdata;
	logic           emit, emit_ign;
	logic [15:0]    emit_cell;
	logic           cur_we, attr_we, fill_we;
	logic [4:0]     cur_r_d;
	logic [6:0]     cur_c_d;
	logic [7:0]     attr_d;
	logic [15:0]    fill_d;
	logic           ptr_clr, ptr_inc;
	logic           pend_d;
	logic [AW-1:0]  pend_addr_d;

	// helpers on the head item and the cursor
	logic                   col_last, row_last, adv_row, needs_scroll;
	logic [CELL_ADDR_W-1:0] cur_lin;
	logic                   copy_phase, ptr_last;
	logic                   cur_in_bounds;

	assign col_last     = (cur_c_q == 7'(COLUMNS - 1));
	assign row_last     = (cur_r_q == 5'(ROWS - 1));
	assign adv_row      = q_head.newline || col_last;
	assign needs_scroll = (cmd_t'(q_head.cmd) == CMD_PUT_CURSOR) && adv_row && row_last;
	assign cur_lin      = CELL_ADDR_W'(cur_r_q) * CELL_ADDR_W'(COLUMNS) + CELL_ADDR_W'(cur_c_q);
	assign copy_phase   = (ptr_q < AW'(COPY_END));
	assign ptr_last     = (ptr_q == AW'(CELLS - 1));
	assign cur_in_bounds = ({1'b0, cur_r_q} < 6'(ROWS)) && ({1'b0, cur_c_q} < 8'(COLUMNS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_INIT: begin
				if (ptr_last) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					unique case (cmd_t'(q_head.cmd))
						CMD_PUT_CURSOR: state_d = needs_scroll ? B_SCROLL : B_IDLE;
						CMD_CLEAR:      state_d = B_CLEAR;
						CMD_READ:       state_d = q_head.on_screen ? B_READ : B_IDLE;
						default:        state_d = B_IDLE;
					endcase
				end
			end
			B_READ: state_d = B_IDLE;
			B_SCROLL: begin
				if (!copy_phase && !pend_s1 && ptr_last) state_d = B_IDLE;
			end
			B_CLEAR: begin
				if (ptr_last) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		we          = 1'b0;
		waddr       = '0;
		wdata       = '0;
		re          = 1'b0;
		raddr       = '0;
		pop         = 1'b0;
		emit        = 1'b0;
		emit_cell   = '0;
		emit_ign    = 1'b0;
		cur_we      = 1'b0;
		cur_r_d     = cur_r_q;
		cur_c_d     = cur_c_q;
		attr_we     = 1'b0;
		attr_d      = attr_q;
		fill_we     = 1'b0;
		fill_d      = fill_q;
		ptr_clr     = 1'b0;
		ptr_inc     = 1'b0;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_s1;
		unique case (state_q)
			B_INIT: begin
				we      = 1'b1;
				waddr   = ptr_q;
				wdata   = fill_q;
				ptr_inc = 1'b1;
			end
			B_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (cmd_t'(q_head.cmd))
						CMD_PUT_CURSOR: begin
							we      = !q_head.newline;
							waddr   = cur_lin[AW-1:0];
							wdata   = {attr_q, q_head.char_code};
							cur_we  = 1'b1;
							cur_c_d = adv_row ? '0 : cur_c_q + 1'b1;
							cur_r_d = (adv_row && !row_last) ? cur_r_q + 1'b1 : cur_r_q;
							emit    = !needs_scroll;
							ptr_clr = 1'b1;
						end
						CMD_PUT_POS: begin
							we       = q_head.on_screen;
							waddr    = q_head.addr[AW-1:0];
							wdata    = {q_head.color, q_head.char_code};
							emit     = 1'b1;
							emit_ign = !q_head.on_screen;
						end
						CMD_SET_CURSOR: begin
							cur_we   = q_head.on_screen;
							cur_r_d  = q_head.row;
							cur_c_d  = q_head.col;
							emit     = 1'b1;
							emit_ign = !q_head.on_screen;
						end
						CMD_SET_COLOR: begin
							attr_we = 1'b1;
							attr_d  = q_head.color;
							emit    = 1'b1;
						end
						CMD_CLEAR: begin
							attr_we = 1'b1;
							attr_d  = q_head.color;
							cur_we  = 1'b1;
							cur_r_d = '0;
							cur_c_d = '0;
							fill_we = 1'b1;
							fill_d  = {q_head.color, BLANK_CHAR};
							ptr_clr = 1'b1;
						end
						CMD_READ: begin
							re       = q_head.on_screen;
							raddr    = q_head.addr[AW-1:0];
							emit     = !q_head.on_screen;
							emit_ign = !q_head.on_screen;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			B_READ: begin
				emit      = 1'b1;
				emit_cell = rdata_q;
			end
			B_SCROLL: begin
				// copy phase reads one row ahead, the write lands in the following cycle
				if (pend_s1) begin
					we    = 1'b1;
					waddr = pend_addr_s1;
					wdata = rdata_q;
				end
				if (copy_phase) begin
					re          = 1'b1;
					raddr       = ptr_q + AW'(COLUMNS);
					pend_d      = 1'b1;
					pend_addr_d = ptr_q;
					ptr_inc     = 1'b1;
				end else if (!pend_s1) begin
					we      = 1'b1;
					waddr   = ptr_q;
					wdata   = {attr_q, BLANK_CHAR};
					ptr_inc = 1'b1;
					emit    = ptr_last;
				end
			end
			B_CLEAR: begin
				we      = 1'b1;
				waddr   = ptr_q;
				wdata   = fill_q;
				ptr_inc = 1'b1;
				emit    = ptr_last;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			ptr_q   <= '0;
			pend_s1 <= 1'b0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			attr_q  <= RESET_ATTR;
			fill_q  <= {RESET_ATTR, BLANK_CHAR};
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= pend_d;
			done_q  <= emit;
			if (ptr_clr) begin
				ptr_q <= '0;
			end else if (ptr_inc) begin
				ptr_q <= ptr_last ? '0 : ptr_q + 1'b1;
			end
			if (cur_we) begin
				cur_r_q <= cur_r_d;
				cur_c_q <= cur_c_d;
			end
			if (attr_we) attr_q <= attr_d;
			if (fill_we) fill_q <= fill_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_addr_s1 <= pend_addr_d;
		if (emit) begin
			cell_q <= emit_cell;
			ign_q  <= emit_ign;
		end
	end

	// screen store
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	// result ports
	assign init_busy     = (state_q == B_INIT);
	assign done          = done_q;
	assign cursor_row    = cur_r_q;
	assign cursor_col    = cur_c_q;
	assign current_color = attr_q;
	assign cell_data     = cell_q;
	assign ignored       = ign_q;

	`include "text_console_writer_top_assert.svh"

	`TCW_ASSERT_ALWAYS(a_cursor_on_screen, cur_in_bounds, "cursor left the screen")
	`TCW_ASSERT_NEXT(a_read_answers, state_q == B_READ, done_q, "read gave no result")
	`TCW_ASSERT_ALWAYS(a_pend_in_scroll, !pend_s1 || (state_q == B_SCROLL), "row copy outside scroll")
	`TCW_ASSERT_ALWAYS(a_pop_in_idle, !pop || (state_q == B_IDLE), "item taken while busy")

endmodule

// ===== src/text_console_writer_top.sv =====
// ---------------------------------------------------------------------------
// text_console_writer_top
// text-mode console engine over a ROWS x COLUMNS character-cell store
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot hold it off. Items pass through a two-entry queue, so start may be
// pulsed every cycle while busy is low. Most commands are carried out by
// the back end from its idle state as it pops them, with done registered
// from that; a cell read also passes the registered store read. A put at the
// cursor that runs past the last row scrolls the store, and a clear sweeps
// it, both cell by cell through the single write port of the cell store.
// After reset the store is swept to blank light grey while busy stays high.
// ---------------------------------------------------------------------------
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  char_code,
	input  logic [4:0]  row,
	input  logic [6:0]  col,
	input  logic [7:0]  color,
	output logic        done,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [7:0]  current_color,
	output logic [15:0] cell_data,
	output logic        ignored
);
	import tcw_pkg::*;

	logic  push, pop, q_valid, q_full, init_busy;
	item_t push_item, q_head;

	// busy while the queue is full or the store is being cleared after reset
	assign busy = q_full || init_busy;

	// front: accept and classify
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.start    (start),
		.busy     (busy),
		.command  (command),
		.char_code(char_code),
		.row      (row),
		.col      (col),
		.color    (color),
		.push     (push),
		.item     (push_item)
	);

	// queue between front and back
	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.valid    (q_valid),
		.full     (q_full),
		.head     (q_head)
	);

	// back: execute on the screen store
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.pop          (pop),
		.init_busy    (init_busy),
		.done         (done),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.current_color(current_color),
		.cell_data    (cell_data),
		.ignored      (ignored)
	);

endmodule
